### hdl/dkda_pkg.sv
`timescale 1ns / 1ps
// Package for the two-key debounce and auto-repeat block.
// Holds the key phase type, result codes, register indexes and reset values.
package dkda_pkg;

  localparam int unsigned TICK_W    = 32;
  localparam int unsigned MS_W      = 16;
  localparam int unsigned CODE_W    = 2;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned NUM_KEYS  = 2;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [MS_W-1:0]   ms_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_HELD    = 2'd2
  } phase_t;

  localparam code_t CODE_NONE = 2'd0;
  localparam code_t CODE_KEY0 = 2'd1;
  localparam code_t CODE_KEY1 = 2'd2;

  localparam reg_idx_t REG_REPEAT_ENABLE = 2'd0;
  localparam reg_idx_t REG_DEBOUNCE_MS   = 2'd1;
  localparam reg_idx_t REG_REPEAT_MS     = 2'd2;

  localparam logic RST_REPEAT_ENABLE = 1'b0;
  localparam ms_t  RST_DEBOUNCE_MS   = 16'd10;
  localparam ms_t  RST_REPEAT_MS     = 16'd200;

endpackage

### hdl/dkda_in_if.sv
`timescale 1ns / 1ps
// Input channel: one scan word with two active-low key levels and a time stamp.
// Depends on dkda_pkg.
interface dkda_in_if;
  logic               valid;
  logic               ready;
  logic               key0_level;
  logic               key1_level;
  dkda_pkg::tick_t    now_tick;

  modport source (output valid, output key0_level, output key1_level, output now_tick,
                  input ready);
  modport sink   (input valid, input key0_level, input key1_level, input now_tick,
                  output ready);
endinterface

### hdl/dkda_out_if.sv
`timescale 1ns / 1ps
// Result channel: one key code word per scan.
// Depends on dkda_pkg.
interface dkda_out_if;
  logic            valid;
  logic            ready;
  dkda_pkg::code_t key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

### hdl/dkda_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
// Depends on dkda_pkg.
interface dkda_cfg_if;
  logic               valid;
  logic               ready;
  dkda_pkg::reg_idx_t reg_index;
  dkda_pkg::ms_t      wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

### hdl/dual_key_debounce_autorepeat.sv
`timescale 1ns / 1ps
// Two-key debounce with auto-repeat. A scan passes an input register, then a result
// register that holds the key code word; while the result waits, the scan stays in the
// input register. Throughput: one scan per cycle while the result channel is not stalled;
// the only loop is the per-key phase and stamp update, one subtract and compare per key.
// Reset (rst_n low, synchronous) sets both keys idle with zero stamps, empties both
// stages and loads the register defaults. Configuration words are always accepted.
module dual_key_debounce_autorepeat (
  input  logic       clk,
  input  logic       rst_n,
  dkda_in_if.sink    in_ch,
  dkda_out_if.source out_ch,
  dkda_cfg_if.sink   cfg_ch
);

  localparam int unsigned NK = dkda_pkg::NUM_KEYS;

  // Configuration registers.
  logic          repeat_enable_r;
  dkda_pkg::ms_t debounce_ms_r;
  dkda_pkg::ms_t repeat_ms_r;

  // Input register.
  logic            s1_valid_r;
  logic [NK-1:0]   s1_low_r;
  dkda_pkg::tick_t s1_now_r;

  // Key machines.
  dkda_pkg::phase_t phase_r   [NK];
  dkda_pkg::phase_t phase_nxt [NK];
  dkda_pkg::tick_t  stamp_r   [NK];
  dkda_pkg::tick_t  stamp_nxt [NK];
  logic [NK-1:0]    report;

  // Result register.
  logic            out_valid_r;
  dkda_pkg::code_t key_code_r;
  dkda_pkg::code_t key_code_nxt;

  logic s1_advance;
  logic in_fire;

  assign s1_advance   = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.key_code = key_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repeat_enable_r <= dkda_pkg::RST_REPEAT_ENABLE;
      debounce_ms_r   <= dkda_pkg::RST_DEBOUNCE_MS;
      repeat_ms_r     <= dkda_pkg::RST_REPEAT_MS;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        dkda_pkg::REG_REPEAT_ENABLE: repeat_enable_r <= cfg_ch.wdata[0];
        dkda_pkg::REG_DEBOUNCE_MS:   debounce_ms_r   <= cfg_ch.wdata;
        dkda_pkg::REG_REPEAT_MS:     repeat_ms_r     <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_low_r <= {!in_ch.key1_level, !in_ch.key0_level};
      s1_now_r <= in_ch.now_tick;
    end
  end

  for (genvar k = 0; k < NK; k++) begin : g_key
    dkda_pkg::tick_t elapsed;
    logic            debounce_done;
    logic            repeat_due;

    // Differences wrap modulo 2^32, as the time stamp does.
    assign elapsed       = s1_now_r - stamp_r[k];
    assign debounce_done = elapsed >= dkda_pkg::tick_t'(debounce_ms_r);
    assign repeat_due    = repeat_enable_r && (elapsed >= dkda_pkg::tick_t'(repeat_ms_r));

    // Next phase and stamp.
    always_comb begin
      phase_nxt[k] = phase_r[k];
      stamp_nxt[k] = stamp_r[k];
      case (phase_r[k])
        dkda_pkg::PH_CONFIRM: begin
          if (!s1_low_r[k]) begin
            phase_nxt[k] = dkda_pkg::PH_IDLE;
          end else if (debounce_done) begin
            phase_nxt[k] = dkda_pkg::PH_HELD;
          end
        end
        dkda_pkg::PH_HELD: begin
          if (!s1_low_r[k]) begin
            phase_nxt[k] = dkda_pkg::PH_IDLE;
          end else if (repeat_due) begin
            stamp_nxt[k] = s1_now_r;
          end
        end
        default: begin
          phase_nxt[k] = dkda_pkg::PH_IDLE;
          if (s1_low_r[k]) begin
            phase_nxt[k] = dkda_pkg::PH_CONFIRM;
            stamp_nxt[k] = s1_now_r;
          end
        end
      endcase
    end

    // Report output of the machine.
    always_comb begin
      case (phase_r[k])
        dkda_pkg::PH_CONFIRM: report[k] = s1_low_r[k] && debounce_done;
        dkda_pkg::PH_HELD:    report[k] = s1_low_r[k] && repeat_due;
        default:              report[k] = 1'b0;
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        phase_r[k] <= dkda_pkg::PH_IDLE;
        stamp_r[k] <= '0;
      end else if (s1_advance) begin
        phase_r[k] <= phase_nxt[k];
        stamp_r[k] <= stamp_nxt[k];
      end
    end
  end

  // Key 1 takes priority when both keys report in the same scan.
  always_comb begin
    if (report[1]) begin
      key_code_nxt = dkda_pkg::CODE_KEY1;
    end else if (report[0]) begin
      key_code_nxt = dkda_pkg::CODE_KEY0;
    end else begin
      key_code_nxt = dkda_pkg::CODE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      key_code_r <= key_code_nxt;
    end
  end

endmodule

### sim/key_code_checker.sv
`timescale 1ns / 1ps
// Key code checker for the two-key debounce block: predicts a key code for every accepted
// scan word from its own copy of the key machines and registers, and compares it with the
// block's result words. Depends on dkda_pkg and the three channel interfaces.
module key_code_checker (
  input  logic clk,
  input  logic rst_n,
  dkda_in_if   scan,
  dkda_out_if  result,
  dkda_cfg_if  regs,
  output int   mismatch_count,
  output int   codes_pending
);

  logic             auto_repeat;
  dkda_pkg::ms_t    debounce_ticks;
  dkda_pkg::ms_t    repeat_ticks;
  dkda_pkg::phase_t key_phase [dkda_pkg::NUM_KEYS];
  dkda_pkg::tick_t  key_stamp [dkda_pkg::NUM_KEYS];
  dkda_pkg::code_t  expected_codes [$];
  int               fails = 0;

  // Moves one key machine on by a scan; returns 1 when the key reports in this scan.
  function automatic logic advance_key(input int k, input logic pressed,
                                       input dkda_pkg::tick_t now);
    dkda_pkg::tick_t elapsed;
    logic            fires;
    elapsed = now - key_stamp[k];
    fires   = 1'b0;
    case (key_phase[k])
      dkda_pkg::PH_CONFIRM: begin
        if (!pressed) begin
          key_phase[k] = dkda_pkg::PH_IDLE;
        end else if (elapsed >= debounce_ticks) begin
          fires        = 1'b1;
          key_phase[k] = dkda_pkg::PH_HELD;
        end
      end
      dkda_pkg::PH_HELD: begin
        if (!pressed) begin
          key_phase[k] = dkda_pkg::PH_IDLE;
        end else if (auto_repeat && elapsed >= repeat_ticks) begin
          fires        = 1'b1;
          key_stamp[k] = now;
        end
      end
      default: begin
        // The unused phase encoding behaves as idle.
        key_phase[k] = pressed ? dkda_pkg::PH_CONFIRM : dkda_pkg::PH_IDLE;
        if (pressed) begin
          key_stamp[k] = now;
        end
      end
    endcase
    return fires;
  endfunction

  // Both machines always advance; key 1 overrides key 0 when both report.
  function automatic dkda_pkg::code_t predict_code(input logic lvl0, input logic lvl1,
                                                   input dkda_pkg::tick_t now);
    dkda_pkg::code_t code;
    code = dkda_pkg::CODE_NONE;
    if (advance_key(0, !lvl0, now)) begin
      code = dkda_pkg::CODE_KEY0;
    end
    if (advance_key(1, !lvl1, now)) begin
      code = dkda_pkg::CODE_KEY1;
    end
    return code;
  endfunction

  always @(posedge clk) begin
    dkda_pkg::code_t want;
    if (!rst_n) begin
      auto_repeat    = dkda_pkg::RST_REPEAT_ENABLE;
      debounce_ticks = dkda_pkg::RST_DEBOUNCE_MS;
      repeat_ticks   = dkda_pkg::RST_REPEAT_MS;
      for (int k = 0; k < dkda_pkg::NUM_KEYS; k++) begin
        key_phase[k] = dkda_pkg::PH_IDLE;
        key_stamp[k] = '0;
      end
      expected_codes.delete();
    end else begin
      if (regs.valid && regs.ready) begin
        case (regs.reg_index)
          dkda_pkg::REG_REPEAT_ENABLE: auto_repeat    = regs.wdata[0];
          dkda_pkg::REG_DEBOUNCE_MS:   debounce_ticks = regs.wdata;
          dkda_pkg::REG_REPEAT_MS:     repeat_ticks   = regs.wdata;
          default: ;
        endcase
      end
      // Results are taken before new scans, so a word can never be matched with the scan
      // accepted at the same edge.
      if (result.valid && result.ready) begin
        if (expected_codes.size() == 0) begin
          fails++;
          if (fails <= 10) begin
            $display("%0t: key code word %0d arrived with no scan outstanding",
                     $time, result.key_code);
          end
        end else begin
          want = expected_codes.pop_front();
          if (result.key_code !== want) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: key code mismatch, expected %0d, got %0d",
                       $time, want, result.key_code);
            end
          end
        end
      end
      if (scan.valid && scan.ready) begin
        expected_codes.push_back(predict_code(scan.key0_level, scan.key1_level,
                                              scan.now_tick));
      end
    end
    mismatch_count <= fails;
    codes_pending  <= expected_codes.size();
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Top of the debounce testbench: clock, reset, scan and register stimulus, result back-pressure
// and the verdict. Depends on dkda_pkg, the channel interfaces and key_code_checker.
module testbench;

  localparam int                 RANDOM_SETTINGS   = 8;
  localparam int                 SCANS_PER_SETTING = 170;
  localparam int                 CYCLE_LIMIT       = 1_000_000;
  localparam dkda_pkg::reg_idx_t REG_UNMAPPED      = 2'd3;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            steady;
  int              stall_left;
  int              fail_total;
  int              pending_total;
  int              cycle_count;
  int              scans_sent = 0;
  int              settings_used = 1;
  dkda_pkg::ms_t   cur_debounce;
  dkda_pkg::ms_t   cur_repeat;
  dkda_pkg::tick_t clock_now;

  dkda_in_if  in_ch();
  dkda_out_if out_ch();
  dkda_cfg_if cfg_ch();

  dual_key_debounce_autorepeat DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  key_code_checker code_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .scan           (in_ch),
    .result         (out_ch),
    .regs           (cfg_ch),
    .mismatch_count (fail_total),
    .codes_pending  (pending_total)
  );

  always #4 clk = ~clk;

  // Mostly no gap, some short ones and a few long ones; none in steady stretches.
  function automatic int gap_length();
    int roll;
    if (steady) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic dkda_pkg::ms_t pick_ticks();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return dkda_pkg::ms_t'($urandom_range(1, 40));
      4: return dkda_pkg::ms_t'($urandom_range(41, 2000));
      default: return dkda_pkg::ms_t'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left = gap_length();
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_scan(input logic lvl0, input logic lvl1, input dkda_pkg::tick_t stamp);
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.key0_level <= lvl0;
    in_ch.key1_level <= lvl1;
    in_ch.now_tick   <= stamp;
    do @(posedge clk); while (!in_ch.ready);
    scans_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_total != 0) @(posedge clk);
  endtask

  task automatic write_reg(input dkda_pkg::reg_idx_t idx, input dkda_pkg::ms_t data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Registers change only once every result word has come back.
  task automatic load_settings(input dkda_pkg::ms_t enable_word, input dkda_pkg::ms_t debounce,
                               input dkda_pkg::ms_t period, input logic stray);
    drain_results();
    write_reg(dkda_pkg::REG_REPEAT_ENABLE, enable_word);
    write_reg(dkda_pkg::REG_DEBOUNCE_MS, debounce);
    write_reg(dkda_pkg::REG_REPEAT_MS, period);
    if (stray) begin
      write_reg(REG_UNMAPPED, dkda_pkg::ms_t'($urandom));
    end
    cfg_ch.valid <= 1'b0;
    cur_debounce = debounce;
    cur_repeat   = period;
    settings_used++;
  endtask

  // Keys are held and released in runs of scans, with single-scan contact bounce mixed in.
  // Time steps scale with the larger of the two intervals so presses and repeats both occur.
  task automatic run_random_phase(input int count);
    int   run_left [dkda_pkg::NUM_KEYS];
    logic level [dkda_pkg::NUM_KEYS];
    logic sent [dkda_pkg::NUM_KEYS];
    int   step_max;
    step_max = ((cur_debounce > cur_repeat ? cur_debounce : cur_repeat) >> 3) + 2;
    if ($urandom_range(0, 2) == 0) begin
      clock_now = 32'hFFFF_FFFF - $urandom_range(0, 20 * step_max);
    end else begin
      clock_now = $urandom;
    end
    for (int k = 0; k < dkda_pkg::NUM_KEYS; k++) begin
      level[k]    = 1'b1;
      run_left[k] = $urandom_range(1, 8);
    end
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < dkda_pkg::NUM_KEYS; k++) begin
        if (run_left[k] == 0) begin
          level[k]    = ~level[k];
          run_left[k] = level[k] ? $urandom_range(1, 8) : $urandom_range(1, 40);
        end
        run_left[k]--;
        sent[k] = ($urandom_range(0, 9) == 0) ? ~level[k] : level[k];
      end
      if ($urandom_range(0, 49) == 0) begin
        clock_now = $urandom;
      end else begin
        clock_now += $urandom_range(0, step_max);
      end
      if ($urandom_range(0, 149) == 0) begin
        drain_results();
      end
      send_scan(sent[0], sent[1], clock_now);
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d result words outstanding",
             cycle_count, pending_total);
    $display("[dual_key_debounce_autorepeat] ERROR");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    steady           = 1'b0;
    stall_left       = 0;
    in_ch.valid      = 1'b0;
    in_ch.key0_level = 1'b1;
    in_ch.key1_level = 1'b1;
    in_ch.now_tick   = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = dkda_pkg::REG_REPEAT_ENABLE;
    cfg_ch.wdata     = '0;
    cur_debounce     = dkda_pkg::RST_DEBOUNCE_MS;
    cur_repeat       = dkda_pkg::RST_REPEAT_MS;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: ten-tick debounce, repeat off.
    send_scan(1'b1, 1'b1, 32'd0);
    send_scan(1'b0, 1'b1, 32'd100);
    send_scan(1'b0, 1'b1, 32'd109);
    send_scan(1'b0, 1'b1, 32'd110);
    send_scan(1'b0, 1'b0, 32'd5000);
    send_scan(1'b1, 1'b0, 32'd5005);
    send_scan(1'b1, 1'b1, 32'd5006);
    // Both keys confirm across the time stamp wrap; key 1 takes the word.
    send_scan(1'b0, 1'b0, 32'hFFFF_FFFA);
    send_scan(1'b0, 1'b0, 32'h0000_0004);
    send_scan(1'b1, 1'b1, 32'h0000_0004);

    // Zero debounce and zero repeat period: a report on every held scan.
    load_settings(16'hFFFF, 16'h0000, 16'h0000, 1'b1);
    send_scan(1'b0, 1'b1, 32'h8000_0000);
    send_scan(1'b0, 1'b1, 32'h8000_0000);
    send_scan(1'b0, 1'b1, 32'h8000_0000);
    send_scan(1'b0, 1'b0, 32'h8000_0001);
    send_scan(1'b0, 1'b0, 32'h8000_0001);
    send_scan(1'b1, 1'b1, 32'h8000_0002);

    // Full-scale times; the first repeat counts from the original low edge.
    load_settings(16'h0001, 16'hFFFF, 16'hFFFF, 1'b0);
    send_scan(1'b1, 1'b0, 32'h7FFF_0000);
    send_scan(1'b1, 1'b0, 32'h7FFF_FFFE);
    send_scan(1'b1, 1'b0, 32'h7FFF_FFFF);
    send_scan(1'b1, 1'b0, 32'h8000_FFFF);
    send_scan(1'b1, 1'b0, 32'h8001_FFFD);
    send_scan(1'b1, 1'b0, 32'h8001_FFFE);
    send_scan(1'b1, 1'b1, 32'h0000_0000);

    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      steady = (p % 4 == 3);
      case (p)
        0: load_settings(16'hFFFE, 16'h0000, 16'h0000, 1'b1);
        1: load_settings(16'h0001, 16'd3, 16'd5, 1'b1);
        2: load_settings(16'h0001, 16'hFFFF, 16'hFFFF, 1'b0);
        default: load_settings(dkda_pkg::ms_t'($urandom), pick_ticks(), pick_ticks(),
                               1'($urandom_range(0, 1)));
      endcase
      run_random_phase(SCANS_PER_SETTING);
    end
    steady = 1'b0;

    drain_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d scan words under %0d register settings, covering wrapped stamps,",
             scans_sent, settings_used);
    $display("zero and full-scale debounce and repeat times, bounce and simultaneous presses.");
    if (fail_total == 0 && pending_total == 0) begin
      $display("[dual_key_debounce_autorepeat] OK");
    end else begin
      $display("[dual_key_debounce_autorepeat] ERROR");
    end
    $finish;
  end

endmodule

### dual_key_debounce_autorepeat.f
hdl/dkda_pkg.sv
hdl/dkda_in_if.sv
hdl/dkda_out_if.sv
hdl/dkda_cfg_if.sv
hdl/dual_key_debounce_autorepeat.sv
sim/key_code_checker.sv
sim/testbench.sv
